// File: hdl/imp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed max-priority table.
// No dependencies; the interfaces, the core and the checker in hdl/ use this package.
package imp_pkg;

  localparam int ENTRIES_DEF       = 64;
  localparam int PAYLOAD_BITS_DEF  = 32;
  localparam int PRIORITY_BITS_DEF = 16;
  localparam int ACTION_BITS       = 3;
  localparam int STATUS_BITS       = 2;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_ADD     = 3'd0,
    ACT_PROMOTE = 3'd1,
    ACT_READ    = 3'd2,
    ACT_GETMAX  = 3'd3,
    ACT_POPMAX  = 3'd4,
    ACT_CHECK   = 3'd5
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BAD_ID = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EVAL,
    S_SCAN,
    S_FETCH,
    S_REPORT,
    S_HOLD
  } state_t;

endpackage

// File: hdl/imp_req_if.sv
`timescale 1ns / 1ps
// Request channel of the indexed max-priority table: valid/ready plus one action.
// Depends on imp_pkg.
interface imp_req_if #(
  parameter int ID_BITS      = $clog2(imp_pkg::ENTRIES_DEF),
  parameter int PAYLOAD_BITS = imp_pkg::PAYLOAD_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [imp_pkg::ACTION_BITS-1:0] action;
  logic [ID_BITS-1:0]             entry_id;
  logic [PAYLOAD_BITS-1:0]        payload_in;

  modport source (output valid, action, entry_id, payload_in, input ready);
  modport sink   (input valid, action, entry_id, payload_in, output ready);
endinterface

// File: hdl/imp_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the indexed max-priority table: valid/ready plus one result.
// Depends on imp_pkg.
interface imp_rsp_if #(
  parameter int ID_BITS       = $clog2(imp_pkg::ENTRIES_DEF),
  parameter int PAYLOAD_BITS  = imp_pkg::PAYLOAD_BITS_DEF,
  parameter int PRIORITY_BITS = imp_pkg::PRIORITY_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [imp_pkg::STATUS_BITS-1:0] status;
  logic [ID_BITS-1:0]              entry_id_out;
  logic [PAYLOAD_BITS-1:0]         payload_out;
  logic [PRIORITY_BITS-1:0]        priority_out;
  logic                            is_live;

  modport source (output valid, status, entry_id_out, payload_out, priority_out, is_live,
                  input ready);
  modport sink   (input valid, status, entry_id_out, payload_out, priority_out, is_live,
                  output ready);
endinterface

// File: hdl/imp_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module imp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: hdl/indexed_max_priority_table_core.sv
`timescale 1ns / 1ps
// Indexed max-priority table: FSM around a priority/live RAM and a payload RAM.
// Depends on imp_pkg, imp_req_if, imp_rsp_if and imp_ram.
//
// Usage: one request channel (req) carries action, entry_id and payload_in; one
// response channel (rsp) returns exactly one result per accepted request, in order.
// Both channels transfer on a rising edge with valid and ready high.
// One request is in work at a time; req.ready is high only while the block is idle.
// The result sits in an output register, so the next request is taken while it
// waits for rsp.ready. Steps from request transfer to the next possible transfer:
//   add, unknown action, check/promote/read of an id never handed out: decode, hold
//   promote, read, check of a handed-out id: one RAM read, then modify/write, hold
//   get max, pop max: a scan over the n ids handed out so far (at most ENTRIES)
//   that reads one priority RAM entry per cycle, then one payload RAM read when
//   an entry is live, then hold.
// Liveness is the live bit stored beside each priority plus the id fill count,
// so entries past the count are never read and no clearing pass is needed.
// Synchronous reset empties the table at once and drops any pending result.
// While rsp.ready stays low the result holds and at most one further request
// is taken; it then waits until the output register frees.
module indexed_max_priority_table_core #(
  parameter int ENTRIES       = imp_pkg::ENTRIES_DEF,
  parameter int PAYLOAD_BITS  = imp_pkg::PAYLOAD_BITS_DEF,
  parameter int PRIORITY_BITS = imp_pkg::PRIORITY_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  imp_req_if.sink      req,
  imp_rsp_if.source    rsp
);
  localparam int ID_BITS  = $clog2(ENTRIES);
  localparam int CNT_BITS = ID_BITS + 1;
  localparam int PW_BITS  = PRIORITY_BITS + 1;
  localparam logic [CNT_BITS-1:0] ENTRIES_CNT = CNT_BITS'(ENTRIES);

  imp_pkg::state_t state, state_next;

  logic [imp_pkg::ACTION_BITS-1:0] op_action;
  logic [ID_BITS-1:0]              op_id;
  logic [PAYLOAD_BITS-1:0]         op_payload;
  logic [CNT_BITS-1:0]             next_id;

  logic               pri_we, pri_re;
  logic [ID_BITS-1:0] pri_waddr, pri_raddr;
  logic [PW_BITS-1:0] pri_wdata, pri_rdata;
  logic               pay_we, pay_re;
  logic [ID_BITS-1:0] pay_raddr;
  logic [PAYLOAD_BITS-1:0] pay_rdata;

  logic [CNT_BITS-1:0]      scan_addr;
  logic                     cmp_valid;
  logic [ID_BITS-1:0]       cmp_idx;
  logic                     best_found;
  logic [ID_BITS-1:0]       best_id;
  logic [PRIORITY_BITS-1:0] best_pri;

  logic                     res_load;
  imp_pkg::status_t         res_status, res_status_next;
  logic [ID_BITS-1:0]       res_id, res_id_next;
  logic [PAYLOAD_BITS-1:0]  res_payload, res_payload_next;
  logic [PRIORITY_BITS-1:0] res_priority, res_priority_next;
  logic                     res_live, res_live_next;
  logic                     add_ok;

  logic                     out_valid;
  imp_pkg::status_t         out_status;
  logic [ID_BITS-1:0]       out_id;
  logic [PAYLOAD_BITS-1:0]  out_payload;
  logic [PRIORITY_BITS-1:0] out_priority;
  logic                     out_live;

  logic                     req_xfer, out_free;
  logic                     id_known, scan_issue, cur_live;
  logic [PRIORITY_BITS-1:0] cur_pri, pri_inc;

  imp_ram #(.WIDTH(PW_BITS), .DEPTH(ENTRIES)) u_pri_ram (
    .clk(clk), .we(pri_we), .waddr(pri_waddr), .wdata(pri_wdata),
    .re(pri_re), .raddr(pri_raddr), .rdata(pri_rdata)
  );

  imp_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(ENTRIES)) u_pay_ram (
    .clk(clk), .we(pay_we), .waddr(next_id[ID_BITS-1:0]), .wdata(op_payload),
    .re(pay_re), .raddr(pay_raddr), .rdata(pay_rdata)
  );

  assign req.ready  = (state == imp_pkg::S_IDLE);
  assign req_xfer   = req.valid && req.ready;
  assign out_free   = !out_valid || rsp.ready;
  assign id_known   = ({1'b0, op_id} < next_id);
  assign scan_issue = (scan_addr < next_id);
  assign cur_live   = pri_rdata[PRIORITY_BITS];
  assign cur_pri    = pri_rdata[PRIORITY_BITS-1:0];
  assign pri_inc    = (&cur_pri) ? cur_pri : cur_pri + PRIORITY_BITS'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      imp_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = imp_pkg::S_DECODE;
        end
      end
      imp_pkg::S_DECODE: begin
        unique case (imp_pkg::action_t'(op_action))
          imp_pkg::ACT_PROMOTE, imp_pkg::ACT_READ, imp_pkg::ACT_CHECK: begin
            state_next = id_known ? imp_pkg::S_EVAL : imp_pkg::S_HOLD;
          end
          imp_pkg::ACT_GETMAX, imp_pkg::ACT_POPMAX: begin
            state_next = imp_pkg::S_SCAN;
          end
          default: begin
            state_next = imp_pkg::S_HOLD;
          end
        endcase
      end
      imp_pkg::S_EVAL: begin
        state_next = imp_pkg::S_HOLD;
      end
      imp_pkg::S_SCAN: begin
        if (!scan_issue) begin
          state_next = imp_pkg::S_FETCH;
        end
      end
      imp_pkg::S_FETCH: begin
        state_next = best_found ? imp_pkg::S_REPORT : imp_pkg::S_HOLD;
      end
      imp_pkg::S_REPORT: begin
        state_next = imp_pkg::S_HOLD;
      end
      imp_pkg::S_HOLD: begin
        if (out_free) begin
          state_next = imp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = imp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    pri_we            = 1'b0;
    pri_waddr         = op_id;
    pri_wdata         = '0;
    pri_re            = 1'b0;
    pri_raddr         = op_id;
    pay_we            = 1'b0;
    pay_re            = 1'b0;
    pay_raddr         = op_id;
    add_ok            = 1'b0;
    res_load          = 1'b0;
    res_status_next   = imp_pkg::STAT_OK;
    res_id_next       = '0;
    res_payload_next  = '0;
    res_priority_next = '0;
    res_live_next     = 1'b0;
    unique case (state)
      imp_pkg::S_DECODE: begin
        unique case (imp_pkg::action_t'(op_action))
          imp_pkg::ACT_ADD: begin
            res_load = 1'b1;
            if (next_id >= ENTRIES_CNT) begin
              res_status_next = imp_pkg::STAT_FULL;
            end else begin
              add_ok      = 1'b1;
              pri_we      = 1'b1;
              pri_waddr   = next_id[ID_BITS-1:0];
              pri_wdata   = {1'b1, {PRIORITY_BITS{1'b0}}};
              pay_we      = 1'b1;
              res_id_next = next_id[ID_BITS-1:0];
            end
          end
          imp_pkg::ACT_PROMOTE, imp_pkg::ACT_READ: begin
            if (id_known) begin
              pri_re = 1'b1;
              pay_re = 1'b1;
            end else begin
              res_load        = 1'b1;
              res_status_next = imp_pkg::STAT_BAD_ID;
            end
          end
          imp_pkg::ACT_CHECK: begin
            if (id_known) begin
              pri_re = 1'b1;
            end else begin
              res_load = 1'b1;
            end
          end
          imp_pkg::ACT_GETMAX, imp_pkg::ACT_POPMAX: begin
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
      end
      imp_pkg::S_EVAL: begin
        res_load = 1'b1;
        unique case (imp_pkg::action_t'(op_action))
          imp_pkg::ACT_PROMOTE: begin
            if (cur_live) begin
              pri_we            = 1'b1;
              pri_wdata         = {1'b1, pri_inc};
              res_priority_next = pri_inc;
            end else begin
              res_status_next = imp_pkg::STAT_BAD_ID;
            end
          end
          imp_pkg::ACT_READ: begin
            if (cur_live) begin
              res_payload_next  = pay_rdata;
              res_priority_next = cur_pri;
            end else begin
              res_status_next = imp_pkg::STAT_BAD_ID;
            end
          end
          imp_pkg::ACT_CHECK: begin
            res_live_next = cur_live;
          end
          default: begin
          end
        endcase
      end
      imp_pkg::S_SCAN: begin
        pri_re    = scan_issue;
        pri_raddr = scan_addr[ID_BITS-1:0];
      end
      imp_pkg::S_FETCH: begin
        if (best_found) begin
          pay_re    = 1'b1;
          pay_raddr = best_id;
          if (imp_pkg::action_t'(op_action) == imp_pkg::ACT_POPMAX) begin
            pri_we    = 1'b1;
            pri_waddr = best_id;
            pri_wdata = {1'b0, best_pri};
          end
        end else begin
          res_load        = 1'b1;
          res_status_next = imp_pkg::STAT_EMPTY;
        end
      end
      imp_pkg::S_REPORT: begin
        res_load          = 1'b1;
        res_id_next       = best_id;
        res_payload_next  = pay_rdata;
        res_priority_next = best_pri;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= imp_pkg::S_IDLE;
      next_id    <= '0;
      scan_addr  <= '0;
      cmp_valid  <= 1'b0;
      best_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= (state == imp_pkg::S_SCAN) && scan_issue;
      if (add_ok) begin
        next_id <= next_id + CNT_BITS'(1);
      end
      if (req_xfer) begin
        scan_addr  <= '0;
        best_found <= 1'b0;
      end else if (state == imp_pkg::S_SCAN) begin
        if (scan_issue) begin
          scan_addr <= scan_addr + CNT_BITS'(1);
        end
        if (cmp_valid && cur_live && (!best_found || cur_pri >= best_pri)) begin
          best_found <= 1'b1;
        end
      end
      if (state == imp_pkg::S_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      op_action  <= req.action;
      op_id      <= req.entry_id;
      op_payload <= req.payload_in;
    end
    cmp_idx <= scan_addr[ID_BITS-1:0];
    if (state == imp_pkg::S_SCAN && cmp_valid && cur_live &&
        (!best_found || cur_pri >= best_pri)) begin
      best_id  <= cmp_idx;
      best_pri <= cur_pri;
    end
    if (res_load) begin
      res_status   <= res_status_next;
      res_id       <= res_id_next;
      res_payload  <= res_payload_next;
      res_priority <= res_priority_next;
      res_live     <= res_live_next;
    end
    if (state == imp_pkg::S_HOLD && out_free) begin
      out_status   <= res_status;
      out_id       <= res_id;
      out_payload  <= res_payload;
      out_priority <= res_priority;
      out_live     <= res_live;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.entry_id_out = out_id;
  assign rsp.payload_out  = out_payload;
  assign rsp.priority_out = out_priority;
  assign rsp.is_live      = out_live;
endmodule

// File: hdl/imp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for indexed_max_priority_table_core, attached by bind.
// Depends on imp_pkg.
module imp_checker #(
  parameter int ID_BITS       = $clog2(imp_pkg::ENTRIES_DEF),
  parameter int PAYLOAD_BITS  = imp_pkg::PAYLOAD_BITS_DEF,
  parameter int PRIORITY_BITS = imp_pkg::PRIORITY_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [imp_pkg::STATUS_BITS-1:0] rsp_status,
  input logic [ID_BITS-1:0]              rsp_entry_id,
  input logic [PAYLOAD_BITS-1:0]         rsp_payload,
  input logic [PRIORITY_BITS-1:0]        rsp_priority,
  input logic                            rsp_is_live
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_entry_id) && $stable(rsp_payload) && $stable(rsp_priority) &&
      $stable(rsp_is_live))
    else $error("response changed while stalled");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in work");

  a_live_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_is_live |-> rsp_status == imp_pkg::STAT_OK)
    else $error("live flag with error status");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != imp_pkg::STAT_OK |->
      rsp_entry_id == '0 && rsp_payload == '0 && rsp_priority == '0 && !rsp_is_live)
    else $error("error response carries data");

  a_reset_drop: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");
endmodule

bind indexed_max_priority_table_core imp_checker #(
  .ID_BITS(ID_BITS),
  .PAYLOAD_BITS(PAYLOAD_BITS),
  .PRIORITY_BITS(PRIORITY_BITS)
) u_imp_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_status(rsp.status),
  .rsp_entry_id(rsp.entry_id_out),
  .rsp_payload(rsp.payload_out),
  .rsp_priority(rsp.priority_out),
  .rsp_is_live(rsp.is_live)
);
